// File: hdl/rbm_pkg.sv
// Shared types and constants for the RAID block mapper.
`default_nettype none

package rbm_pkg;

  // RAID level codes on the raid_level field.
  localparam logic [1:0] LVL_RAID0 = 2'd0;
  localparam logic [1:0] LVL_RAID1 = 2'd1;
  localparam logic [1:0] LVL_RAID5 = 2'd2;

  localparam int unsigned LB_W     = 15;  // logical block width
  localparam int unsigned BLK_W    = 15;  // pre-offset block width
  localparam int unsigned PBLK_W   = 16;  // offset block width before range check
  localparam int unsigned HEAD_W   = 14;  // head position and output block width
  localparam int unsigned LAT_W    = 15;
  localparam int unsigned STAT_W   = 32;
  localparam int unsigned DELAY_W  = 8;

  localparam logic [PBLK_W-1:0] RAID1_BASE = 16'd2048;
  localparam logic [PBLK_W-1:0] RAID5_BASE = 16'd4096;
  localparam int unsigned       PB_LIMIT   = 16384;
  localparam logic [DELAY_W-1:0] DELAY_RESET = 8'd5;

  // Reciprocal of three: (x * 43691) >> 17 equals x / 3 for any x below 2**16.
  localparam logic [31:0] RECIP3       = 32'd43691;
  localparam int unsigned RECIP3_SHIFT = 17;

  // Mapping of one request to its disk accesses.
  typedef struct packed {
    logic [1:0]       disk_a;
    logic [1:0]       disk_b;
    logic [BLK_W-1:0] block;
    logic [HEAD_W-1:0] pblk;
    logic             two;
    logic             parity_b;
    logic             err;
  } map_t;

  // Seek statistics as seen after one request.
  typedef struct packed {
    logic [LAT_W-1:0]  lat;
    logic [STAT_W-1:0] sum;
    logic [STAT_W-1:0] total;
  } stats_t;

endpackage

`default_nettype wire

// File: hdl/rbm_map.sv
// Address mapping of one logical block to disk accesses for RAID 0, 1 and 5.
`default_nettype none

module rbm_map #(
  parameter int unsigned BLOCKS_PER_DISK = 16384
) (
  input  wire logic [rbm_pkg::LB_W-1:0] lb,
  input  wire logic                     wr,
  input  wire logic [1:0]               lvl,
  output rbm_pkg::map_t                 map
);

  localparam logic [31:0] LIM1 = 32'(BLOCKS_PER_DISK);
  localparam logic [31:0] LIM2 = 32'(2 * BLOCKS_PER_DISK);
  localparam logic [31:0] LIM3 = 32'(3 * BLOCKS_PER_DISK);
  localparam logic [31:0] RANGE_LIMIT =
      (BLOCKS_PER_DISK < rbm_pkg::PB_LIMIT) ? 32'(BLOCKS_PER_DISK) : 32'(rbm_pkg::PB_LIMIT);

  logic [31:0]                  lb_ext;
  logic [31:0]                  r1_rem;
  logic                         r1_pair;
  logic [31:0]                  prod;
  logic [13:0]                  row;
  logic [rbm_pkg::LB_W-1:0]     slot_full;
  logic [1:0]                   slot;
  logic [1:0]                   pd;
  logic [rbm_pkg::BLK_W-1:0]    block;
  logic [rbm_pkg::PBLK_W-1:0]   pblk;
  logic [1:0]                   disk_a;
  logic [1:0]                   disk_b;
  logic                         two;
  logic                         parity_b;
  logic                         lvl_bad;

  assign lb_ext = 32'(lb);

  // RAID 1: the quotient by the disk size is at most three, so a few compares do.
  always_comb begin
    if (lb_ext >= LIM3) begin
      r1_rem  = lb_ext - LIM3;
      r1_pair = 1'b1;
    end else if (lb_ext >= LIM2) begin
      r1_rem  = lb_ext - LIM2;
      r1_pair = 1'b0;
    end else if (lb_ext >= LIM1) begin
      r1_rem  = lb_ext - LIM1;
      r1_pair = 1'b1;
    end else begin
      r1_rem  = lb_ext;
      r1_pair = 1'b0;
    end
  end

  // RAID 5: row and slot by a reciprocal multiply.
  assign prod      = lb_ext * rbm_pkg::RECIP3;
  assign row       = prod[rbm_pkg::RECIP3_SHIFT +: 14];
  assign slot_full = lb - rbm_pkg::LB_W'({row, 1'b0} + {1'b0, row});
  assign slot      = slot_full[1:0];
  assign pd        = row[1:0];

  always_comb begin
    block    = '0;
    pblk     = '0;
    disk_a   = '0;
    disk_b   = '0;
    two      = 1'b0;
    parity_b = 1'b0;
    lvl_bad  = 1'b0;
    unique case (lvl)
      rbm_pkg::LVL_RAID0: begin
        disk_a = lb[1:0];
        block  = rbm_pkg::BLK_W'(lb >> 2);
        pblk   = rbm_pkg::PBLK_W'(block);
      end
      rbm_pkg::LVL_RAID1: begin
        block  = r1_rem[rbm_pkg::BLK_W-1:0];
        pblk   = rbm_pkg::PBLK_W'(block) + rbm_pkg::RAID1_BASE;
        disk_a = {r1_pair, 1'b0};
        disk_b = {r1_pair, 1'b1};
        two    = wr;
      end
      rbm_pkg::LVL_RAID5: begin
        block    = rbm_pkg::BLK_W'(row);
        pblk     = rbm_pkg::PBLK_W'(row) + rbm_pkg::RAID5_BASE;
        disk_a   = (slot < pd) ? slot : slot + 2'd1;
        disk_b   = pd;
        two      = wr;
        parity_b = 1'b1;
      end
      default: begin
        lvl_bad = 1'b1;
      end
    endcase
  end

  always_comb begin
    map.err      = lvl_bad || (32'(pblk) >= RANGE_LIMIT);
    map.disk_a   = map.err ? 2'd0 : disk_a;
    map.disk_b   = disk_b;
    map.block    = block;
    map.pblk     = map.err ? '0 : pblk[rbm_pkg::HEAD_W-1:0];
    map.two      = two && !map.err;
    map.parity_b = parity_b;
  end

endmodule

`default_nettype wire

// File: hdl/rbm_stats.sv
// Head position, rotational delay register and saturating seek statistics.
`default_nettype none

module rbm_stats (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [rbm_pkg::DELAY_W-1:0]   cfg_wdata,
  input  wire logic                          commit,
  input  wire rbm_pkg::map_t                 map,
  output rbm_pkg::stats_t                    stats
);

  logic [rbm_pkg::DELAY_W-1:0] rot_delay;
  logic [rbm_pkg::HEAD_W-1:0]  head;
  logic [rbm_pkg::STAT_W-1:0]  acc;
  logic [rbm_pkg::STAT_W-1:0]  cnt;

  logic [rbm_pkg::HEAD_W-1:0]  blk;
  logic [rbm_pkg::HEAD_W-1:0]  seek_len;
  logic [rbm_pkg::LAT_W-1:0]   lat;
  logic [rbm_pkg::STAT_W:0]    sum_wide;
  logic [rbm_pkg::STAT_W-1:0]  acc_next;
  logic [rbm_pkg::STAT_W-1:0]  cnt_next;

  // A request that passes the range check always has a block below 16384.
  assign blk      = map.block[rbm_pkg::HEAD_W-1:0];
  assign seek_len = (blk >= head) ? blk - head : head - blk;
  assign lat      = rbm_pkg::LAT_W'(seek_len) + rbm_pkg::LAT_W'(rot_delay);
  assign sum_wide = {1'b0, acc} + (rbm_pkg::STAT_W + 1)'(lat);
  assign acc_next = sum_wide[rbm_pkg::STAT_W] ? '1 : sum_wide[rbm_pkg::STAT_W-1:0];
  assign cnt_next = (&cnt) ? cnt : cnt + 1'b1;

  always_comb begin
    if (map.err) begin
      stats.lat   = '0;
      stats.sum   = acc;
      stats.total = cnt;
    end else begin
      stats.lat   = lat;
      stats.sum   = acc_next;
      stats.total = cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rot_delay <= rbm_pkg::DELAY_RESET;
      head      <= '0;
      acc       <= '0;
      cnt       <= '0;
    end else begin
      if (cfg_we) begin
        rot_delay <= cfg_wdata;
      end
      if (commit && !map.err) begin
        head <= blk;
        acc  <= acc_next;
        cnt  <= cnt_next;
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/rbm_out.sv
// Result register that presents one or two disk accesses per request.
`default_nettype none

module rbm_out (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          load,
  input  wire logic                          load_wr,
  input  wire rbm_pkg::map_t                 map,
  input  wire rbm_pkg::stats_t               stats,
  input  wire logic                          out_stall,
  output logic                               out_valid,
  output logic                               free,
  output logic [1:0]                         disk_index,
  output logic [rbm_pkg::HEAD_W-1:0]         physical_block,
  output logic                               access_is_write,
  output logic                               is_parity,
  output logic                               range_error,
  output logic [rbm_pkg::LAT_W-1:0]          request_latency,
  output logic [rbm_pkg::STAT_W-1:0]         latency_sum,
  output logic [rbm_pkg::STAT_W-1:0]         request_total,
  output logic                               last
);

  logic            valid;
  logic            phase;
  rbm_pkg::map_t   map_q;
  rbm_pkg::stats_t stats_q;
  logic            wr_q;
  logic            take;

  assign take = valid && !out_stall;
  assign last = phase || !map_q.two;
  assign free = !valid || (take && last);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      phase <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
      phase <= 1'b0;
    end else if (take) begin
      if (last) begin
        valid <= 1'b0;
      end else begin
        phase <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      map_q   <= map;
      stats_q <= stats;
      wr_q    <= load_wr;
    end
  end

  assign out_valid       = valid;
  assign disk_index      = phase ? map_q.disk_b : map_q.disk_a;
  assign physical_block  = map_q.pblk;
  assign access_is_write = wr_q;
  assign is_parity       = phase && map_q.parity_b;
  assign range_error     = map_q.err;
  assign request_latency = stats_q.lat;
  assign latency_sum     = stats_q.sum;
  assign request_total   = stats_q.total;

endmodule

`default_nettype wire

// File: hdl/raid_block_mapper_with_seek_stats.sv
// Top level of the RAID block mapper with seek statistics.
// An accepted item passes the input register, then the result register that shows it.
// Throughput: one item per cycle when it maps to one access and out_stall is low; a
// mirrored or parity write holds the single result register until both accesses go.
// Reset (rst, synchronous): clears the pipeline, head position and totals, and loads
// the rotational delay with 5.
`default_nettype none

module raid_block_mapper_with_seek_stats #(
  parameter int unsigned BLOCKS_PER_DISK = 16384
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // Configuration: rotational delay register.
  input  wire logic                          cfg_we,
  input  wire logic [rbm_pkg::DELAY_W-1:0]   cfg_wdata,
  // Request channel.
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [rbm_pkg::LB_W-1:0]      lba,
  input  wire logic                          is_write,
  input  wire logic [1:0]                    raid_level,
  // Access channel.
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [1:0]                         disk_index,
  output logic [rbm_pkg::HEAD_W-1:0]         physical_block,
  output logic                               access_is_write,
  output logic                               is_parity,
  output logic                               range_error,
  output logic [rbm_pkg::LAT_W-1:0]          request_latency,
  output logic [rbm_pkg::STAT_W-1:0]         latency_sum,
  output logic [rbm_pkg::STAT_W-1:0]         request_total,
  output logic                               last
);

  // Input register. It refills in the same cycle it hands its item to the
  // result register, so the input side waits only while the result register is neither
  // empty nor handing over its last access.
  logic                         in_full;
  logic [rbm_pkg::LB_W-1:0]     lb_q;
  logic                         wr_q;
  logic [1:0]                   lvl_q;
  logic                         accept;
  logic                         advance;
  logic                         out_free;

  rbm_pkg::map_t   map;
  rbm_pkg::stats_t stats;

  assign advance  = in_full && out_free;
  assign in_stall = in_full && !advance;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (accept) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      lb_q  <= lba;
      wr_q  <= is_write;
      lvl_q <= raid_level;
    end
  end

  // Combinational mapping of the held item to its disks and blocks.
  rbm_map #(
    .BLOCKS_PER_DISK(BLOCKS_PER_DISK)
  ) u_map (
    .lb (lb_q),
    .wr (wr_q),
    .lvl(lvl_q),
    .map(map)
  );

  // Seek accounting. The state moves when the item enters the result register,
  // which keeps it in request order.
  rbm_stats u_stats (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .commit   (advance),
    .map      (map),
    .stats    (stats)
  );

  // Result register: sends the first access, then the second one if any.
  rbm_out u_out (
    .clk            (clk),
    .rst            (rst),
    .load           (advance),
    .load_wr        (wr_q),
    .map            (map),
    .stats          (stats),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .free           (out_free),
    .disk_index     (disk_index),
    .physical_block (physical_block),
    .access_is_write(access_is_write),
    .is_parity      (is_parity),
    .range_error    (range_error),
    .request_latency(request_latency),
    .latency_sum    (latency_sum),
    .request_total  (request_total),
    .last           (last)
  );

endmodule

`default_nettype wire

// File: hdl/rbm_checker.sv
// Port-level checker for the RAID block mapper, bound to the top level.
`default_nettype none

module rbm_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic [1:0]                    disk_index,
  input wire logic [rbm_pkg::HEAD_W-1:0]    physical_block,
  input wire logic                          access_is_write,
  input wire logic                          is_parity,
  input wire logic                          range_error,
  input wire logic [rbm_pkg::LAT_W-1:0]     request_latency,
  input wire logic [rbm_pkg::STAT_W-1:0]    latency_sum,
  input wire logic [rbm_pkg::STAT_W-1:0]    request_total,
  input wire logic                          last
);

  // A stalled item holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(disk_index)
      && $stable(physical_block) && $stable(last) && $stable(request_total))
    else $error("stalled access changed");

  // A rejected request is a single plain access with no latency.
  a_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && range_error |-> last && !is_parity && request_latency == '0
      && disk_index == 2'd0 && physical_block == '0)
    else $error("range error access malformed");

  // Parity is only the closing write of a request.
  a_par: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_parity |-> last && access_is_write && !range_error)
    else $error("parity access malformed");

  // The second access of a request follows at once with the same totals.
  a_second: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last |=> out_valid && last && $stable(request_total)
      && $stable(latency_sum) && $stable(physical_block))
    else $error("second access missing or altered");

  // A served request has been counted.
  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && !range_error |-> request_total != '0)
    else $error("served request not counted");

endmodule

bind raid_block_mapper_with_seek_stats rbm_checker u_rbm_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .disk_index     (disk_index),
  .physical_block (physical_block),
  .access_is_write(access_is_write),
  .is_parity      (is_parity),
  .range_error    (range_error),
  .request_latency(request_latency),
  .latency_sum    (latency_sum),
  .request_total  (request_total),
  .last           (last)
);

`default_nettype wire
